FILE: rtl/core/wrnl_pkg.sv
// shared widths and constants for the windowed rms noise level meter
// no dependencies; imported by wrnl_level and windowed_rms_noise_level
`default_nettype none

package wrnl_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW     = 32;
  localparam int WIN_LOG2   = 5;
  localparam int CNT_W      = 5;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = SQ_W + WIN_LOG2;
  localparam int MEAN_W     = SUM_W - WIN_LOG2;
  localparam int ROOT_W     = MEAN_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int BIT_CNT_W  = 4;

  localparam logic [SAMPLE_W-1:0] MID_RESET = 12'd2048;

  // level = root * 60 / 1000 + 30, reduced to root * 3 / 50
  localparam int LEVEL_NUM   = 60;
  localparam int LEVEL_DEN   = 1000;
  localparam int LEVEL_MUL   = LEVEL_NUM / 20;
  localparam int LEVEL_DIV   = LEVEL_DEN / 20;
  localparam int LEVEL_W     = 9;
  localparam int PROD_W      = ROOT_W + 2;
  localparam int QUO_W       = 8;
  localparam int DSH_W       = 13;

  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 9'd30;
  localparam logic [DSH_W-1:0]   DIV_START   = DSH_W'(LEVEL_DIV << (QUO_W - 1));

endpackage

`default_nettype wire

FILE: rtl/core/wrnl_level.sv
// end-of-window unit: digit-by-digit square root, then serial divide for the level
// depends on wrnl_pkg
`default_nettype none

module wrnl_level
  import wrnl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [SUM_W-1:0]    sum,
  output logic                     out_valid,
  output logic [ROOT_W-1:0]        out_rms_value,
  output logic [LEVEL_W-1:0]       out_level
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_SQRT,
    U_MUL,
    U_DIV
  } ustate_t;

  ustate_t                st_r;
  logic [MEAN_W-1:0]      mean_sh_r;
  logic [REM_W-1:0]       rem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [BIT_CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]      p_r;
  logic [DSH_W-1:0]       dsh_r;
  logic [QUO_W-1:0]       q_r;
  logic                   valid_r;
  logic [ROOT_W-1:0]      rms_r;
  logic [LEVEL_W-1:0]     level_r;

  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic                   sq_ge;
  logic                   dv_ge;
  logic [QUO_W-1:0]       q_nxt;

  // two mean bits enter the partial remainder each step
  assign rem_sh = {rem_r[ROOT_W-1:0], mean_sh_r[MEAN_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);
  assign dv_ge  = (p_r >= PROD_W'(dsh_r));
  assign q_nxt  = {q_r[QUO_W-2:0], dv_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= U_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= 1'b0;
      case (st_r)
        U_IDLE: begin
          if (go) begin
            mean_sh_r <= sum[SUM_W-1:WIN_LOG2];
            rem_r     <= '0;
            root_r    <= '0;
            cnt_r     <= '0;
            st_r      <= U_SQRT;
          end
        end
        U_SQRT: begin
          rem_r     <= sq_ge ? (rem_sh - trial) : rem_sh;
          root_r    <= {root_r[ROOT_W-2:0], sq_ge};
          mean_sh_r <= mean_sh_r << 2;
          cnt_r     <= cnt_r + 1'b1;
          if (cnt_r == BIT_CNT_W'(ROOT_W - 1)) begin
            st_r <= U_MUL;
          end
        end
        U_MUL: begin
          p_r   <= PROD_W'(root_r) * PROD_W'(LEVEL_MUL);
          dsh_r <= DIV_START;
          q_r   <= '0;
          cnt_r <= '0;
          st_r  <= U_DIV;
        end
        U_DIV: begin
          if (dv_ge) begin
            p_r <= p_r - PROD_W'(dsh_r);
          end
          dsh_r <= dsh_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == BIT_CNT_W'(QUO_W - 1)) begin
            valid_r <= 1'b1;
            rms_r   <= root_r;
            level_r <= LEVEL_W'(q_nxt) + LEVEL_FLOOR;
            st_r    <= U_IDLE;
          end
        end
        default: begin
          st_r <= U_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = valid_r;
  assign out_rms_value = rms_r;
  assign out_level     = level_r;

endmodule

`default_nettype wire

FILE: rtl/core/windowed_rms_noise_level.sv
// top level of the windowed rms noise level meter: bit-serial square accumulate
// depends on wrnl_pkg and wrnl_level
`default_nettype none

// A sample is taken when start is high and busy is low. Its deviation from
// cfg mid_point is squared by a bit-serial shift-add into the window sum, one
// multiplier bit per cycle, and busy stays high until its last bit is added.
// The sample that completes a 32-sample window also runs the end-of-window
// unit: a 12-step square root (two mean bits per cycle), a scaling step and
// an 8-step serial divide by 50; that sample keeps busy high until its result
// is out, so no new sample is accepted before that result.
// The result beat is on out_rms_value and out_level for the one cycle that
// out_valid is high; the receiver cannot stall it. Write cfg_data with cfg_we
// only while busy is low.
module windowed_rms_noise_level
  import wrnl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_data,
  output logic                     out_valid,
  output logic [ROOT_W-1:0]        out_rms_value,
  output logic [LEVEL_W-1:0]       out_level
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_ROOT
  } state_t;

  state_t                 state_r;
  logic [SAMPLE_W-1:0]    mid_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       count_r;
  logic [SAMPLE_W-1:0]    dev_sh_r;
  logic [SQ_W-1:0]        mcand_r;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;
  logic                   root_go_r;

  logic [SAMPLE_W-1:0]    dev;
  logic                   accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign dev    = (in_sample >= mid_r) ? (in_sample - mid_r) : (mid_r - in_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= MID_RESET;
    end else if (cfg_we) begin
      mid_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sum_r     <= '0;
      count_r   <= '0;
      bit_cnt_r <= '0;
      root_go_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            dev_sh_r  <= dev;
            mcand_r   <= SQ_W'(dev);
            bit_cnt_r <= '0;
            state_r   <= S_MAC;
          end
        end
        S_MAC: begin
          // shift-add square straight into the window sum
          if (dev_sh_r[0]) begin
            sum_r <= sum_r + SUM_W'(mcand_r);
          end
          dev_sh_r  <= dev_sh_r >> 1;
          mcand_r   <= mcand_r << 1;
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == BIT_CNT_W'(SAMPLE_W - 1)) begin
            if (count_r == CNT_W'(WINDOW - 1)) begin
              count_r   <= '0;
              root_go_r <= 1'b1;
              state_r   <= S_ROOT;
            end else begin
              count_r <= count_r + 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_ROOT: begin
          // unit latches the sum on the go cycle, so it can be cleared then
          if (root_go_r) begin
            root_go_r <= 1'b0;
            sum_r     <= '0;
          end
          if (out_valid) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  wrnl_level u_level (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (root_go_r),
    .sum           (sum_r),
    .out_valid     (out_valid),
    .out_rms_value (out_rms_value),
    .out_level     (out_level)
  );

endmodule

`default_nettype wire
